// ===== src/trcq_pkg.sv =====
`default_nettype none

package trcq_pkg;

   localparam int QUEUE_DEPTH = 8;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int LEVEL_W     = 8;
   localparam int HOLD_W      = 16;
   localparam int QUEUED_W    = 4;
   localparam int ENTRY_W     = 3 * LEVEL_W + HOLD_W;

   localparam int CSR_AW      = 3;
   localparam int CSR_DW      = 32;

   // command codes
   localparam logic [2:0] CMD_TICK  = 3'd0;
   localparam logic [2:0] CMD_SET   = 3'd1;
   localparam logic [2:0] CMD_QUEUE = 3'd2;
   localparam logic [2:0] CMD_SAVE  = 3'd3;
   localparam logic [2:0] CMD_LOAD  = 3'd4;

   // register word select (paddr bit 2)
   localparam logic REG_LED_MODE = 1'b0;

   typedef struct packed {
      logic [LEVEL_W-1:0] blue;
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] red;
   } color_type;

   typedef struct packed {
      logic [HOLD_W-1:0] hold;
      color_type         color;
   } entry_type;

   typedef struct packed {
      logic load;   // capture the incoming beat
      logic exec;   // apply the captured command and load the result register
   } ctl_cmd_type;

   function automatic logic [LEVEL_W-1:0] map_level(input logic [LEVEL_W-1:0] v,
                                                    input logic            on_off);
      if (on_off)
         return (v != '0) ? '1 : '0;
      return v;
   endfunction

endpackage

`default_nettype wire

// ===== src/timed_rgb_color_queue_unit.sv =====
// Timed RGB colour queue: drives an RGB LED from a steady colour plus a ring
// queue of temporary colours, each shown for its hold time in milliseconds.
// Request channel (req_*): one beat per command; tuser carries the command
// (tick, set steady, queue, save, load), tdata the colour and hold time.
// A tick beat advances time by one millisecond.
// Response channel (rsp_*): exactly one beat per request, in order, giving the
// colour now shown after the on/off or pwm mapping, the accept flag, whether
// the colour came from the queue, and the number of queued colours.
// Each request is captured in the capture register, then runs against the queue
// RAM and loads the result register once that register is free; req_tready is
// low until the captured command has run, so requests are taken one at a time.
// A request may be taken while the previous response still waits.
// When the receiver stalls the response holds, and the next request waits in
// its capture register until the response register is free.
// Reset (synchronous) empties the queue, zeroes hold time and the steady, saved
// and shown colours, selects pwm mode; queue RAM contents are not cleared, no clearing pass.
// led_mode sits at csr byte address 0 (bit 0); pready is always high.
`default_nettype none

module timed_rgb_color_queue_unit
   import trcq_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [39:0]       req_tdata,  // red[7:0], green[15:8], blue[23:16], hold_ms[39:24]
   input  wire logic [2:0]        req_tuser,  // cmd[2:0]
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [31:0]            rsp_tdata,  // red_out[7:0], green_out[15:8], blue_out[23:16],
                                              // queued[27:24], zero[31:28]
   output logic [1:0]             rsp_tuser,  // accepted[0], from_queue[1]
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0]      csr_prdata,
   output logic                   csr_pready
);

   ctl_cmd_type           ctl;
   color_type             color_in;
   color_type             color_out;
   logic                  accepted;
   logic                  from_queue;
   logic [QUEUED_W-1:0]   queued;

   assign color_in.red   = req_tdata[7:0];
   assign color_in.green = req_tdata[15:8];
   assign color_in.blue  = req_tdata[23:16];

   trcq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctl        (ctl)
   );

   trcq_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .cmd         (req_tuser),
      .color_in    (color_in),
      .hold_ms     (req_tdata[39:24]),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .color_out   (color_out),
      .accepted    (accepted),
      .from_queue  (from_queue),
      .queued      (queued)
   );

   assign rsp_tdata  = {4'b0000, queued, color_out.blue, color_out.green, color_out.red};
   assign rsp_tuser  = {from_queue, accepted};
   assign csr_pready = 1'b1;

endmodule

`default_nettype wire

// ===== src/trcq_ram.sv =====
`default_nettype none

module trcq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/trcq_ctrl.sv =====
`default_nettype none

module trcq_ctrl
   import trcq_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  wire logic  rsp_tready,
   output ctl_cmd_type ctl
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign ctl.load   = req_tvalid && req_tready;
   // result register must be free, or emptied this cycle
   assign ctl.exec   = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (ctl.load) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (ctl.exec) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.exec)
         rsp_valid_in = 1'b1;
      else if (rsp_tready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== src/trcq_dp.sv =====
`default_nettype none

module trcq_dp
   import trcq_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ctl_cmd_type         ctl,
   input  wire logic [2:0]          cmd,
   input  wire color_type           color_in,
   input  wire logic [HOLD_W-1:0]   hold_ms,
   input  wire logic                csr_psel,
   input  wire logic                csr_penable,
   input  wire logic                csr_pwrite,
   input  wire logic [CSR_AW-1:0]   csr_paddr,
   input  wire logic [CSR_DW-1:0]   csr_pwdata,
   output logic      [CSR_DW-1:0]   csr_prdata,
   output color_type                color_out,
   output logic                     accepted,
   output logic                     from_queue,
   output logic [QUEUED_W-1:0]      queued
);

   // captured beat
   logic [2:0]        cmd_ff;
   color_type         color_ff;
   logic [HOLD_W-1:0] hold_ff;

   // block state
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [HOLD_W-1:0] hold_left_ff, hold_left_in;
   color_type         steady_ff, steady_in;
   color_type         saved_ff, saved_in;
   color_type         shown_ff, shown_in;
   logic              shown_fq_ff, shown_fq_in;
   logic              led_mode_ff, led_mode_in;

   // result register
   color_type             out_color_ff;
   logic                  out_acc_ff, out_acc_in;
   logic                  out_fq_ff;
   logic [QUEUED_W-1:0]   out_queued_ff;

   logic                  ram_wr_en;
   entry_type             ram_wr_data;
   entry_type             ram_rd_data;
   logic [HOLD_W-1:0]     hold_dec;
   logic                  queue_full;
   logic [CNT_W+QUEUED_W-1:0] count_ext;

   trcq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_ptr_ff),
      .wr_data (ram_wr_data),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rd_data)
   );

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(QUEUE_DEPTH - 1))
         return '0;
      return p + PTR_W'(1);
   endfunction

   assign hold_dec    = (hold_left_ff != '0) ? hold_left_ff - HOLD_W'(1) : hold_left_ff;
   assign queue_full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign ram_wr_data = '{hold: hold_ff, color: color_ff};

   // read data holds the head entry: read_ptr is stable from the capture edge on
   always_comb begin
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      count_in     = count_ff;
      hold_left_in = hold_left_ff;
      steady_in    = steady_ff;
      saved_in     = saved_ff;
      shown_in     = shown_ff;
      shown_fq_in  = shown_fq_ff;
      out_acc_in   = 1'b1;
      ram_wr_en    = 1'b0;
      if (ctl.exec) begin
         case (cmd_ff)
            CMD_TICK: begin
               hold_left_in = hold_dec;
               if (hold_dec == '0) begin
                  if (count_ff != '0) begin
                     shown_in     = ram_rd_data.color;
                     hold_left_in = ram_rd_data.hold;
                     shown_fq_in  = 1'b1;
                     rd_ptr_in    = next_ptr(rd_ptr_ff);
                     count_in     = count_ff - CNT_W'(1);
                  end else begin
                     shown_in    = steady_ff;
                     shown_fq_in = 1'b0;
                  end
               end
            end
            CMD_SET: begin
               steady_in   = color_ff;
               shown_in    = color_ff;
               shown_fq_in = 1'b0;
            end
            CMD_QUEUE: begin
               if (queue_full) begin
                  out_acc_in = 1'b0;
               end else begin
                  ram_wr_en = 1'b1;
                  wr_ptr_in = next_ptr(wr_ptr_ff);
                  count_in  = count_ff + CNT_W'(1);
               end
            end
            CMD_SAVE: saved_in  = steady_ff;
            CMD_LOAD: steady_in = saved_ff;
            default: ;
         endcase
      end
   end

   assign count_ext = {{QUEUED_W{1'b0}}, count_in};

   // register interface
   always_comb begin
      led_mode_in = led_mode_ff;
      if (csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == REG_LED_MODE))
         led_mode_in = csr_pwdata[0];
   end

   assign csr_prdata = (csr_paddr[2] == REG_LED_MODE) ?
                       {{(CSR_DW-1){1'b0}}, led_mode_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         hold_left_ff <= '0;
         steady_ff    <= '0;
         saved_ff     <= '0;
         shown_ff     <= '0;
         shown_fq_ff  <= 1'b0;
         led_mode_ff  <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         hold_left_ff <= hold_left_in;
         steady_ff    <= steady_in;
         saved_ff     <= saved_in;
         shown_ff     <= shown_in;
         shown_fq_ff  <= shown_fq_in;
         led_mode_ff  <= led_mode_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff   <= cmd;
         color_ff <= color_in;
         hold_ff  <= hold_ms;
      end
      if (ctl.exec) begin
         out_color_ff.red   <= map_level(shown_in.red, led_mode_ff);
         out_color_ff.green <= map_level(shown_in.green, led_mode_ff);
         out_color_ff.blue  <= map_level(shown_in.blue, led_mode_ff);
         out_acc_ff         <= out_acc_in;
         out_fq_ff          <= shown_fq_in;
         out_queued_ff      <= count_ext[QUEUED_W-1:0];
      end
   end

   assign color_out  = out_color_ff;
   assign accepted   = out_acc_ff;
   assign from_queue = out_fq_ff;
   assign queued     = out_queued_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue fill count beyond depth");

   a_ptrs_meet: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || queue_full) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with fill count");

   a_refused_keeps: assert property (@(posedge clock) disable iff (reset)
      (ctl.exec && !out_acc_in) |=> ($stable(count_ff) && $stable(wr_ptr_ff)))
      else $error("refused queue beat changed the queue");

   a_no_write_on_tick: assert property (@(posedge clock) disable iff (reset)
      (ram_wr_en) |-> (ctl.exec && cmd_ff == CMD_QUEUE && !queue_full))
      else $error("queue written outside an accepted queue beat");

endmodule

`default_nettype wire

// ===== tb/sv/timed_rgb_color_queue_unit_test.sv =====
`default_nettype none

module timed_rgb_color_queue_unit_test;
   import trcq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0]        CMD_SPARE_LO  = 3'd5;
   localparam logic [2:0]        CMD_SPARE_MID = 3'd6;
   localparam logic [2:0]        CMD_SPARE_HI  = 3'd7;
   localparam logic [CSR_AW-1:0] LED_MODE_ADDR = {REG_LED_MODE, 2'b00};
   localparam logic              MODE_PWM      = 1'b0;
   localparam logic              MODE_ON_OFF   = 1'b1;
   localparam int                PHASE_ITEMS   = 360;
   localparam int                CYCLE_LIMIT   = 200000;

   typedef struct {
      logic [LEVEL_W-1:0]  red;
      logic [LEVEL_W-1:0]  green;
      logic [LEVEL_W-1:0]  blue;
      logic                accepted;
      logic                from_queue;
      logic [QUEUED_W-1:0] queued;
   } led_beat_type;

   class led_queue_scoreboard;
      entry_type        store [QUEUE_DEPTH];
      int unsigned      wr_idx;
      int unsigned      rd_idx;
      int unsigned      fill;
      logic [HOLD_W-1:0] hold_left;
      color_type        steady;
      color_type        saved;
      color_type        shown;
      logic             shown_from_queue;
      logic             on_off;
      led_beat_type     pending_leds [$];
      int               errors;

      function new();
         wr_idx           = 0;
         rd_idx           = 0;
         fill             = 0;
         hold_left        = '0;
         steady           = '0;
         saved            = '0;
         shown            = '0;
         shown_from_queue = 1'b0;
         on_off           = MODE_PWM;
         errors           = 0;
      endfunction

      function void set_on_off(logic mode);
         on_off = mode;
      endfunction

      function logic [LEVEL_W-1:0] drive_level(logic [LEVEL_W-1:0] v);
         if (on_off == MODE_ON_OFF)
            return (v == 0) ? 8'h00 : 8'hFF;
         return v;
      endfunction

      // advance the shadow state by one command and queue the beat it should answer
      function void note_command(logic [2:0] cmd, logic [39:0] data);
         color_type         c;
         logic [HOLD_W-1:0] h;
         led_beat_type      e;
         c          = data[23:0];
         h          = data[39:24];
         e.accepted = 1'b1;
         case (cmd)
            CMD_TICK: begin
               if (hold_left != 0)
                  hold_left--;
               if (hold_left == 0) begin
                  if (fill > 0) begin
                     shown            = store[rd_idx].color;
                     hold_left        = store[rd_idx].hold;
                     shown_from_queue = 1'b1;
                     rd_idx           = (rd_idx + 1) % QUEUE_DEPTH;
                     fill--;
                  end else begin
                     shown            = steady;
                     shown_from_queue = 1'b0;
                  end
               end
            end
            CMD_SET: begin
               steady           = c;
               shown            = c;
               shown_from_queue = 1'b0;
            end
            CMD_QUEUE: begin
               if (fill >= QUEUE_DEPTH) begin
                  e.accepted = 1'b0;
               end else begin
                  store[wr_idx].color = c;
                  store[wr_idx].hold  = h;
                  wr_idx              = (wr_idx + 1) % QUEUE_DEPTH;
                  fill++;
               end
            end
            CMD_SAVE: saved  = steady;
            CMD_LOAD: steady = saved;
            default: ;
         endcase
         e.red        = drive_level(shown.red);
         e.green      = drive_level(shown.green);
         e.blue       = drive_level(shown.blue);
         e.from_queue = shown_from_queue;
         e.queued     = fill[QUEUED_W-1:0];
         pending_leds.push_back(e);
      endfunction

      function void compare_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
         if (act_v !== exp_v) begin
            $display("%0t %s: expected %h actual %h", $realtime, name, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check_led_beat(logic [31:0] tdata, logic [1:0] tuser);
         led_beat_type e;
         if (pending_leds.size() == 0) begin
            $display("%0t unexpected beat: expected none actual %h/%h",
                     $realtime, tdata, tuser);
            errors++;
            return;
         end
         e = pending_leds.pop_front();
         compare_field("red_out", e.red, tdata[7:0]);
         compare_field("green_out", e.green, tdata[15:8]);
         compare_field("blue_out", e.blue, tdata[23:16]);
         compare_field("queued", 8'(e.queued), 8'(tdata[27:24]));
         compare_field("accepted", 8'(e.accepted), 8'(tuser[0]));
         compare_field("from_queue", 8'(e.from_queue), 8'(tuser[1]));
      endfunction
   endclass

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_tvalid  = 1'b0;
   logic              req_tready;
   logic [39:0]       req_tdata   = '0;
   logic [2:0]        req_tuser   = CMD_TICK;
   logic              rsp_tvalid;
   logic              rsp_tready  = 1'b0;
   logic [31:0]       rsp_tdata;
   logic [1:0]        rsp_tuser;
   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0] csr_paddr   = '0;
   logic [CSR_DW-1:0] csr_pwdata  = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   led_queue_scoreboard sb;
   bit                  bursts_on = 1'b1;
   int                  cycles    = 0;

   timed_rgb_color_queue_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timed_rgb_color_queue_unit: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_led_beat(rsp_tdata, rsp_tuser);
   end

   // receiver back-pressure
   initial begin
      wait (!reset);
      @(posedge clock);
      forever begin
         if (bursts_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   function automatic color_type rgb(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      return {b, g, r};
   endfunction

   function automatic logic [7:0] rand_level();
      int unsigned pick;
      pick = $urandom_range(0, 7);
      if (pick < 2)
         return 8'h00;
      if (pick == 2)
         return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   // leaves tvalid high after the beat so back-to-back beats need no re-raise
   task automatic send_command(logic [2:0] cmd, color_type c, logic [HOLD_W-1:0] h);
      if (bursts_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {h, c};
      do @(posedge clock); while (!req_tready);
      sb.note_command(cmd, {h, c});
   endtask

   task automatic send_random();
      int unsigned       pick;
      logic [2:0]        cmd;
      logic [HOLD_W-1:0] h;
      pick = $urandom_range(0, 99);
      if (pick < 45)
         cmd = CMD_TICK;
      else if (pick < 65)
         cmd = CMD_QUEUE;
      else if (pick < 77)
         cmd = CMD_SET;
      else if (pick < 85)
         cmd = CMD_SAVE;
      else if (pick < 93)
         cmd = CMD_LOAD;
      else
         cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
      // queued holds kept short so the queue keeps turning over
      if (cmd == CMD_QUEUE)
         h = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 3))
                                        : 16'($urandom_range(0, 40));
      else
         h = 16'($urandom_range(0, 16'hFFFF));
      send_command(cmd, rgb(rand_level(), rand_level(), rand_level()), h);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.pending_leds.size() != 0) @(posedge clock);
   endtask

   task automatic write_led_mode(logic mode);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= LED_MODE_ADDR;
      csr_pwdata  <= CSR_DW'(mode);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      sb.set_on_off(mode);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   initial begin
      logic        phase_mode [4];
      logic [15:0] fill_holds [8];
      phase_mode = '{MODE_ON_OFF, MODE_PWM, MODE_ON_OFF, MODE_PWM};
      fill_holds = '{16'd0, 16'd1, 16'd0, 16'd2, 16'd1, 16'd0, 16'd3, 16'd0};
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      write_led_mode(MODE_PWM);

      // directed: save/load, full queue refusal, spare codes, zero holds
      send_command(CMD_TICK, rgb(8'h00, 8'h00, 8'h00), 16'h0000);
      send_command(CMD_SET, rgb(8'hFF, 8'hFF, 8'hFF), 16'hFFFF);
      send_command(CMD_SAVE, rgb(8'h00, 8'h00, 8'h00), 16'h0000);
      send_command(CMD_SET, rgb(8'h00, 8'h00, 8'h00), 16'h0000);
      send_command(CMD_LOAD, rgb(8'hFF, 8'hFF, 8'hFF), 16'hFFFF);
      send_command(CMD_TICK, rgb(8'hFF, 8'h00, 8'hFF), 16'h0000);
      for (int i = 0; i < QUEUE_DEPTH; i++)
         send_command(CMD_QUEUE, rgb(8'(i * 37), 8'hFF - 8'(i), (i % 2) ? 8'hFF : 8'h01),
                      fill_holds[i]);
      send_command(CMD_QUEUE, rgb(8'hFF, 8'hFF, 8'hFF), 16'hFFFF);
      send_command(CMD_SPARE_LO, rgb(8'h12, 8'h34, 8'h56), 16'hFFFF);
      send_command(CMD_SPARE_MID, rgb(8'hFF, 8'h00, 8'h00), 16'h8001);
      send_command(CMD_SPARE_HI, rgb(8'h00, 8'hFF, 8'h00), 16'h7FFE);
      repeat (8) send_command(CMD_TICK, rgb(8'h00, 8'h00, 8'h00), 16'h0000);

      for (int ph = 0; ph < 4; ph++) begin
         wait_drained();
         write_led_mode(phase_mode[ph]);
         bursts_on = (ph != 3);
         repeat (PHASE_ITEMS) send_random();
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (sb.errors == 0)
         $display("timed_rgb_color_queue_unit: match");
      else
         $display("timed_rgb_color_queue_unit: mismatch");
      $finish;
   end

endmodule

`default_nettype wire
